/* design/assert_macros.svh */
// assertion helpers shared by the rtl modules
// each macro expects clk_i and rst_ni in the enclosing scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`else

`define ASSERT_IMPL(name, pre, post, msg)
`define ASSERT_NEXT(name, pre, post, msg)

`endif

`endif

/* design/glmd_pkg.sv */
package glmd_pkg;

  localparam int unsigned HEIGHT_W = 4;
  localparam int unsigned RISK_W   = 23;
  localparam int unsigned OUT_IDX_W = 10;
  localparam logic [RISK_W-1:0] RISK_MAX = {RISK_W{1'b1}};

  // item kinds
  typedef enum logic [0:0] {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } glmd_op_e;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_COLS = 1'b0,
    REG_ROWS = 1'b1
  } glmd_reg_e;

  // line store bank select (row index mod 3)
  typedef logic [1:0] bank_t;

  typedef struct packed {
    glmd_op_e              opcode;
    logic [HEIGHT_W-1:0]   height;
  } in_item_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0]  cell_row;
    logic [OUT_IDX_W-1:0]  cell_col;
    logic [HEIGHT_W-1:0]   cell_height;
    logic                  is_minimum;
    logic [RISK_W-1:0]     risk_total;
    logic                  frame_last;
  } out_item_t;

  // control word from the classifier to the executing back end
  typedef struct packed {
    logic                  wr;         // store height into the line store
    logic                  judge;      // produce a verdict
    logic                  has_up;
    logic                  has_down;
    logic                  has_left;
    logic                  has_right;
    logic                  last;       // final cell of the frame
    bank_t                 wbank;      // bank written
    bank_t                 cbank;      // bank of the judged row
    bank_t                 ubank;      // bank of the row above it
    logic [HEIGHT_W-1:0]   height;     // pixel height, lower neighbour
  } cmd_flags_t;

  function automatic bank_t bank_inc(bank_t b);
    bank_t r;
    r = (b == 2'd2) ? 2'd0 : b + 2'd1;
    return r;
  endfunction

  function automatic bank_t bank_dec(bank_t b);
    bank_t r;
    r = (b == 2'd0) ? 2'd2 : b - 2'd1;
    return r;
  endfunction

endpackage

/* design/grid_local_minimum_detector.sv */
// a verdict goes via the command queue, evaluate stage and result queue to the result ports
// throughput: one item per cycle while full is low; the three line store banks take
// one write and two reads a cycle; a full result queue stalls the back end, and the front
// keeps taking items until the command queue fills
// reset: counters, risk total and queues clear at once; cols/rows reset to 1024 capped by
// MAX_COLS/MAX_ROWS; the line store is not cleared, no clearing pass
module grid_local_minimum_detector #(
  parameter int unsigned MAX_COLS = 1024,
  parameter int unsigned MAX_ROWS = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  glmd_pkg::in_item_t      in_data_i,
  output logic                    empty,
  input  logic                    pop,
  output glmd_pkg::out_item_t     out_data_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int unsigned COL_W   = $clog2(MAX_COLS);
  localparam int unsigned ROW_W   = $clog2(MAX_ROWS);
  localparam int unsigned CW      = $clog2(MAX_COLS + 1);
  localparam int unsigned RW      = $clog2(MAX_ROWS + 1);
  localparam int unsigned CMD_W   = ROW_W + COL_W + $bits(glmd_pkg::cmd_flags_t);
  localparam int unsigned RES_W   = $bits(glmd_pkg::out_item_t);
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned COLS_RST = (MAX_COLS < 1024) ? MAX_COLS : 1024;
  localparam int unsigned ROWS_RST = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;

  logic [CW-1:0]          cols_q, cols_d;
  logic [RW-1:0]          rows_q, rows_d;
  logic [10:0]            wval;
  logic                   cfg_wr;
  glmd_pkg::glmd_reg_e    reg_sel;

  logic                   cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic [ROW_W-1:0]       cmd_row_in, cmd_row_out;
  logic [COL_W-1:0]       cmd_col_in, cmd_col_out;
  glmd_pkg::cmd_flags_t   cmd_flags_in, cmd_flags_out;
  logic [CMD_W-1:0]       cmd_rdata;
  logic                   res_push, res_full;
  glmd_pkg::out_item_t    res_item;
  logic [RES_W-1:0]       res_rdata;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = glmd_pkg::glmd_reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign wval    = pwdata[10:0];

  // clamp written dimensions to the supported range
  always_comb begin
    cols_d = cols_q;
    rows_d = rows_q;
    if (cfg_wr) begin
      unique case (reg_sel)
        glmd_pkg::REG_COLS: begin
          if (wval < 11'd2) begin
            cols_d = CW'(2);
          end else if (32'(wval) > MAX_COLS) begin
            cols_d = CW'(MAX_COLS);
          end else begin
            cols_d = CW'(wval);
          end
        end
        glmd_pkg::REG_ROWS: begin
          if (wval < 11'd2) begin
            rows_d = RW'(2);
          end else if (32'(wval) > MAX_ROWS) begin
            rows_d = RW'(MAX_ROWS);
          end else begin
            rows_d = RW'(wval);
          end
        end
        default: begin
          cols_d = cols_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= CW'(COLS_RST);
      rows_q <= RW'(ROWS_RST);
    end else begin
      cols_q <= cols_d;
      rows_q <= rows_d;
    end
  end

  // register readback
  always_comb begin
    unique case (reg_sel)
      glmd_pkg::REG_COLS: prdata = 32'(cols_q);
      glmd_pkg::REG_ROWS: prdata = 32'(rows_q);
      default:            prdata = '0;
    endcase
  end

  // front: raster tracking and classification
  glmd_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (push && !full),
    .item_i      (in_data_i),
    .cols_i      (cols_q),
    .rows_i      (rows_q),
    .cmd_push_o  (cmd_push),
    .cmd_row_o   (cmd_row_in),
    .cmd_col_o   (cmd_col_in),
    .cmd_flags_o (cmd_flags_in)
  );

  assign full = cmd_full;

  // command queue between front and back
  glmd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (Q_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i ({cmd_row_in, cmd_col_in, cmd_flags_in}),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty)
  );

  assign {cmd_row_out, cmd_col_out, cmd_flags_out} = cmd_rdata;

  // back: line store access and verdict
  glmd_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_row_i   (cmd_row_out),
    .cmd_col_i   (cmd_col_out),
    .cmd_flags_i (cmd_flags_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_item_o  (res_item)
  );

  // result queue
  glmd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (Q_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_item),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign out_data_o = glmd_pkg::out_item_t'(res_rdata);

endmodule

/* design/glmd_fifo.sv */
`include "assert_macros.svh"

module glmd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;
  logic             last_pop;

  assign full_o   = (cnt_q == CNT_W'(DEPTH));
  assign empty_o  = (cnt_q == '0);
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && !empty_o;
  assign last_pop = do_pop && !do_push && (cnt_q == CNT_W'(1));
  assign rdata_o  = data_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wr_ptr_q] <= wdata_i;
    end
  end

  `ASSERT_NEXT(fifo_push_not_empty, do_push && !do_pop, !empty_o, "fifo empty after push")
  `ASSERT_NEXT(fifo_last_pop_empty, last_pop, empty_o, "fifo not empty after last pop")
  `ASSERT_IMPL(fifo_full_not_empty, full_o, !empty_o, "fifo full and empty at once")

endmodule

/* design/glmd_front.sv */
module glmd_front #(
  parameter int unsigned MAX_COLS = 1024,
  parameter int unsigned MAX_ROWS = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  glmd_pkg::in_item_t                   item_i,
  input  logic [$clog2(MAX_COLS + 1)-1:0]      cols_i,
  input  logic [$clog2(MAX_ROWS + 1)-1:0]      rows_i,
  output logic                                 cmd_push_o,
  output logic [$clog2(MAX_ROWS)-1:0]          cmd_row_o,
  output logic [$clog2(MAX_COLS)-1:0]          cmd_col_o,
  output glmd_pkg::cmd_flags_t                 cmd_flags_o
);

  localparam int unsigned COL_W = $clog2(MAX_COLS);
  localparam int unsigned ROW_W = $clog2(MAX_ROWS);
  localparam int unsigned CW    = $clog2(MAX_COLS + 1);
  localparam int unsigned RW    = $clog2(MAX_ROWS + 1);

  logic [ROW_W-1:0]      in_row_q, in_row_d;
  logic [COL_W-1:0]      in_col_q, in_col_d;
  logic [COL_W-1:0]      flush_col_q, flush_col_d;
  glmd_pkg::bank_t       wbank_q, wbank_d;
  logic                  complete_q, complete_d;
  logic                  row_end, grid_end, flush_end;

  // end of row, end of grid, end of last-row flush
  assign row_end   = (CW'(in_col_q) + CW'(1)) >= cols_i;
  assign grid_end  = (RW'(in_row_q) + RW'(1)) >= rows_i;
  assign flush_end = (CW'(flush_col_q) + CW'(1)) >= cols_i;

  // classify the accepted item and advance the raster position
  always_comb begin
    in_row_d    = in_row_q;
    in_col_d    = in_col_q;
    flush_col_d = flush_col_q;
    wbank_d     = wbank_q;
    complete_d  = complete_q;
    cmd_push_o  = 1'b0;
    cmd_row_o   = in_row_q;
    cmd_col_o   = in_col_q;
    cmd_flags_o = '0;
    if (accept_i) begin
      unique case (item_i.opcode)
        glmd_pkg::OP_PIXEL: begin
          if (!complete_q) begin
            cmd_push_o            = 1'b1;
            cmd_row_o             = in_row_q - ROW_W'(1);
            cmd_col_o             = in_col_q;
            cmd_flags_o.wr        = 1'b1;
            cmd_flags_o.judge     = (in_row_q != '0);
            cmd_flags_o.has_up    = (in_row_q > ROW_W'(1));
            cmd_flags_o.has_down  = 1'b1;
            cmd_flags_o.has_left  = (in_col_q != '0);
            cmd_flags_o.has_right = !row_end;
            cmd_flags_o.last      = 1'b0;
            cmd_flags_o.wbank     = wbank_q;
            cmd_flags_o.cbank     = glmd_pkg::bank_dec(wbank_q);
            cmd_flags_o.ubank     = glmd_pkg::bank_dec(glmd_pkg::bank_dec(wbank_q));
            cmd_flags_o.height    = item_i.height;
            if (row_end) begin
              in_col_d = '0;
              if (grid_end) begin
                complete_d  = 1'b1;
                flush_col_d = '0;
              end else begin
                in_row_d = in_row_q + ROW_W'(1);
                wbank_d  = glmd_pkg::bank_inc(wbank_q);
              end
            end else begin
              in_col_d = in_col_q + COL_W'(1);
            end
          end
        end
        glmd_pkg::OP_FLUSH: begin
          if (complete_q) begin
            cmd_push_o            = 1'b1;
            cmd_row_o             = in_row_q;
            cmd_col_o             = flush_col_q;
            cmd_flags_o.wr        = 1'b0;
            cmd_flags_o.judge     = 1'b1;
            cmd_flags_o.has_up    = (in_row_q != '0);
            cmd_flags_o.has_down  = 1'b0;
            cmd_flags_o.has_left  = (flush_col_q != '0);
            cmd_flags_o.has_right = !flush_end;
            cmd_flags_o.last      = flush_end;
            cmd_flags_o.wbank     = wbank_q;
            cmd_flags_o.cbank     = wbank_q;
            cmd_flags_o.ubank     = glmd_pkg::bank_dec(wbank_q);
            cmd_flags_o.height    = '0;
            if (flush_end) begin
              in_row_d    = '0;
              in_col_d    = '0;
              flush_col_d = '0;
              wbank_d     = '0;
              complete_d  = 1'b0;
            end else begin
              flush_col_d = flush_col_q + COL_W'(1);
            end
          end
        end
        default: begin
          cmd_push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q    <= '0;
      in_col_q    <= '0;
      flush_col_q <= '0;
      wbank_q     <= '0;
      complete_q  <= 1'b0;
    end else begin
      in_row_q    <= in_row_d;
      in_col_q    <= in_col_d;
      flush_col_q <= flush_col_d;
      wbank_q     <= wbank_d;
      complete_q  <= complete_d;
    end
  end

endmodule

/* design/glmd_back.sv */
`include "assert_macros.svh"

module glmd_back #(
  parameter int unsigned MAX_COLS = 1024,
  parameter int unsigned MAX_ROWS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_empty_i,
  input  logic [$clog2(MAX_ROWS)-1:0]   cmd_row_i,
  input  logic [$clog2(MAX_COLS)-1:0]   cmd_col_i,
  input  glmd_pkg::cmd_flags_t          cmd_flags_i,
  output logic                          cmd_pop_o,
  input  logic                          res_full_i,
  output logic                          res_push_o,
  output glmd_pkg::out_item_t           res_item_o
);

  localparam int unsigned COL_W = $clog2(MAX_COLS);
  localparam int unsigned ROW_W = $clog2(MAX_ROWS);
  localparam int unsigned HW    = glmd_pkg::HEIGHT_W;
  localparam int unsigned RKW   = glmd_pkg::RISK_W;

  logic                    s1_go;
  logic                    s2_valid_q;
  logic                    s2_done;
  glmd_pkg::cmd_flags_t    s2_flags_q;
  logic [ROW_W-1:0]        s2_row_q;
  logic [COL_W-1:0]        s2_col_q;
  logic [HW-1:0]           rd_a_q [3];
  logic [HW-1:0]           rd_b_q [3];
  logic [HW-1:0]           left_q;
  logic [RKW-1:0]          risk_q;
  logic [COL_W-1:0]        col_p1;
  logic [HW-1:0]           center, right_h, up_h;
  logic                    low;
  logic [RKW:0]            risk_sum;
  logic [RKW-1:0]          risk_new;

  // issue stage moves when the evaluate stage is free or draining
  assign s2_done    = s2_valid_q && (!s2_flags_q.judge || !res_full_i);
  assign s1_go      = !cmd_empty_i && (!s2_valid_q || s2_done);
  assign cmd_pop_o  = s1_go;
  assign col_p1     = cmd_col_i + COL_W'(1);

  // three row banks, each written at the pixel column and read at col and col+1
  for (genvar b = 0; b < 3; b++) begin : g_bank
    logic [HW-1:0] row_mem [MAX_COLS];

    always_ff @(posedge clk_i) begin
      if (s1_go) begin
        if (cmd_flags_i.wr && cmd_flags_i.wbank == glmd_pkg::bank_t'(b)) begin
          row_mem[cmd_col_i] <= cmd_flags_i.height;
        end
        rd_a_q[b] <= row_mem[cmd_col_i];
        rd_b_q[b] <= row_mem[col_p1];
      end
    end
  end

  // evaluate stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_go) begin
      s2_valid_q <= 1'b1;
    end else if (s2_done) begin
      s2_valid_q <= 1'b0;
    end
  end

  // evaluate stage payload
  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s2_flags_q <= cmd_flags_i;
      s2_row_q   <= cmd_row_i;
      s2_col_q   <= cmd_col_i;
    end
  end

  // neighbour compare and risk accumulation
  always_comb begin
    center  = rd_a_q[s2_flags_q.cbank];
    right_h = rd_b_q[s2_flags_q.cbank];
    up_h    = rd_a_q[s2_flags_q.ubank];
    low     = (!s2_flags_q.has_up    || center < up_h) &&
              (!s2_flags_q.has_down  || center < s2_flags_q.height) &&
              (!s2_flags_q.has_left  || center < left_q) &&
              (!s2_flags_q.has_right || center < right_h);
    risk_sum = {1'b0, risk_q} + (low ? ((RKW + 1)'(center) + (RKW + 1)'(1)) : '0);
    risk_new = risk_sum[RKW] ? glmd_pkg::RISK_MAX : risk_sum[RKW-1:0];
  end

  assign res_push_o = s2_valid_q && s2_flags_q.judge && !res_full_i;

  always_comb begin
    res_item_o             = '0;
    res_item_o.cell_row    = glmd_pkg::OUT_IDX_W'(s2_row_q);
    res_item_o.cell_col    = glmd_pkg::OUT_IDX_W'(s2_col_q);
    res_item_o.cell_height = center;
    res_item_o.is_minimum  = low;
    res_item_o.risk_total  = risk_new;
    res_item_o.frame_last  = s2_flags_q.last;
  end

  // running risk, cleared after the final verdict
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      risk_q <= '0;
    end else if (res_push_o) begin
      risk_q <= s2_flags_q.last ? '0 : risk_new;
    end
  end

  // judged cell becomes the left neighbour of the next one
  always_ff @(posedge clk_i) begin
    if (res_push_o) begin
      left_q <= center;
    end
  end

  `ASSERT_NEXT(back_risk_clear, res_push_o && s2_flags_q.last, risk_q == '0, "risk not cleared at frame end")
  `ASSERT_NEXT(back_stall_hold, s2_valid_q && !s2_done, s2_valid_q && $stable(s2_col_q), "evaluate stage lost a stalled verdict")
  `ASSERT_IMPL(back_no_pop_empty, cmd_pop_o, !cmd_empty_i, "command popped from empty queue")

endmodule
